@@ rtl/tmf_pkg.sv @@
package tmf_pkg;

	localparam int unsigned MAX_BATCH_DEF = 32;
	localparam int unsigned SAMPLE_W      = 16;
	localparam int unsigned BLEN_W        = 6;
	localparam int unsigned TRIM_W        = 4;
	localparam int unsigned CFG_IDX_W     = 1;
	localparam int unsigned CFG_DATA_W    = 6;
	localparam int unsigned BLEN_RESET    = 8;
	localparam int unsigned TRIM_RESET    = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BATCH_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIM_COUNT   = 1'b1;

	// batch job handed from front to back
	typedef struct packed {
		logic [BLEN_W-1:0] len;
		logic [TRIM_W-1:0] trim;
		logic              err;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LOAD,
		BK_SORT,
		BK_SUM,
		BK_DIV,
		BK_OUT
	} bk_state_t;

endpackage

@@ rtl/trimmed_mean_filter_core.sv @@
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | sample[15:0]
// out     | output    | out_valid / out_stall| average[15:0], config_error
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data[5:0]
// A sample is taken each cycle unless both sample banks hold batches not yet loaded.
// The back end uses a one compare-exchange per cycle sorter and a bit-serial divider.
// Sample memory is ping-ponged per batch so the front keeps filling during the sort.
// arst_n clears fill count, queue, state and registers (length 8, trim 2).
// cfg_ready is always high; writes are expected only while the block is idle.
module trimmed_mean_filter_core #(
	parameter int unsigned MAX_BATCH = tmf_pkg::MAX_BATCH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [tmf_pkg::SAMPLE_W-1:0]   sample,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [tmf_pkg::SAMPLE_W-1:0]   average,
	output logic                           config_error,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tmf_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned AW = $clog2(MAX_BATCH);

	logic [tmf_pkg::BLEN_W-1:0] blen_q;
	logic [tmf_pkg::TRIM_W-1:0] trim_q;
	logic                       len_we;

	assign cfg_ready = 1'b1;
	assign len_we    = cfg_valid && cfg_index == tmf_pkg::REG_BATCH_LENGTH;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blen_q <= tmf_pkg::BLEN_W'(tmf_pkg::BLEN_RESET);
			trim_q <= tmf_pkg::TRIM_W'(tmf_pkg::TRIM_RESET);
		end else if (cfg_valid) begin
			case (cfg_index)
				tmf_pkg::REG_BATCH_LENGTH: blen_q <= cfg_data;
				tmf_pkg::REG_TRIM_COUNT:   trim_q <= cfg_data[tmf_pkg::TRIM_W-1:0];
				default: ;
			endcase
		end
	end

	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic [tmf_pkg::SAMPLE_W-1:0] wr_data;
	logic                         job_push, job_pop;
	tmf_pkg::job_t                job_in;
	tmf_pkg::job_t                job_q [2];
	logic                         wp_q, rp_q, fbank_q, rbank_q;
	logic [1:0]                   cnt_q;
	logic [1:0]                   bank_cnt_q;
	logic                         bank_done;
	logic                         job_full, job_valid;
	logic [AW-1:0]                rd_addr;
	logic [tmf_pkg::SAMPLE_W-1:0] rd_data;

	tmf_front #(.MAX_BATCH(MAX_BATCH)) u_front (
		.clk, .arst_n, .in_valid, .in_sample(sample), .in_stall,
		.cfg_len_we(len_we), .cfg_len(blen_q), .trim(trim_q),
		.wr_en, .wr_addr, .wr_data, .job_push, .job(job_in), .job_full
	);

	// bank select: the front writes bank fbank, the back loads bank rbank
	tmf_ram #(.WIDTH(tmf_pkg::SAMPLE_W), .DEPTH(2 * (1 << AW))) u_ram (
		.clk, .we(wr_en), .waddr({fbank_q, wr_addr}), .wdata(wr_data),
		.raddr({rbank_q, rd_addr}), .rdata(rd_data)
	);

	// a bank is held from its job push until the back end has loaded it
	assign job_full  = bank_cnt_q == 2'd2;
	assign job_valid = cnt_q != 2'd0;

	// two-entry job queue, one per sample bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0; fbank_q <= 1'b0;
			rbank_q <= 1'b0; bank_cnt_q <= '0;
		end else begin
			if (job_push) begin
				wp_q    <= !wp_q;
				fbank_q <= !fbank_q;
			end
			if (job_pop) rp_q <= !rp_q;
			if (bank_done) rbank_q <= !rbank_q;
			cnt_q      <= cnt_q + 2'(job_push) - 2'(job_pop);
			bank_cnt_q <= bank_cnt_q + 2'(job_push) - 2'(bank_done);
		end
	end

	always_ff @(posedge clk) begin
		if (job_push) job_q[wp_q] <= job_in;
	end

	tmf_back #(.MAX_BATCH(MAX_BATCH)) u_back (
		.clk, .arst_n, .job_valid, .job(job_q[rp_q]), .job_pop, .bank_done,
		.rd_addr, .rd_data, .out_valid, .out_stall, .average, .config_error
	);

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("job queue overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		job_full |-> !job_push)
		else $error("push into full queue");
	a_bank_match: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> fbank_q == rp_q)
		else $error("bank pointer mismatch");
	a_bank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bank_cnt_q != 2'd3)
		else $error("sample bank overflow");

endmodule

@@ rtl/tmf_ram.sv @@
module tmf_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/tmf_front.sv @@
module tmf_front #(
	parameter int unsigned MAX_BATCH = tmf_pkg::MAX_BATCH_DEF,
	localparam int unsigned AW = $clog2(MAX_BATCH),
	localparam int unsigned CW = $clog2(MAX_BATCH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [tmf_pkg::SAMPLE_W-1:0]  in_sample,
	output logic                          in_stall,
	input  logic                          cfg_len_we,
	input  logic [tmf_pkg::BLEN_W-1:0]    cfg_len,
	input  logic [tmf_pkg::TRIM_W-1:0]    trim,
	// sample write into the bank being filled
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic [tmf_pkg::SAMPLE_W-1:0]  wr_data,
	// job push
	output logic                          job_push,
	output tmf_pkg::job_t                 job,
	input  logic                          job_full
);

	logic [CW-1:0]               fill_q;
	logic [tmf_pkg::BLEN_W-1:0]  eff_len;
	logic                        last;
	logic                        acc;
	logic [tmf_pkg::TRIM_W:0]    trim2;

	// clamp batch length to 1..MAX_BATCH
	always_comb begin
		if (cfg_len == '0) begin
			eff_len = tmf_pkg::BLEN_W'(1);
		end else if (32'(cfg_len) > MAX_BATCH) begin
			eff_len = tmf_pkg::BLEN_W'(MAX_BATCH);
		end else begin
			eff_len = cfg_len;
		end
	end

	assign last     = (32'(fill_q) + 1) >= 32'(eff_len);
	// every sample waits while both sample banks are still held by batches
	assign in_stall = job_full;
	assign acc      = in_valid && !in_stall;
	assign trim2    = {trim, 1'b0};

	assign wr_en   = acc && (32'(fill_q) < MAX_BATCH);
	assign wr_addr = fill_q[AW-1:0];
	assign wr_data = in_sample;

	assign job_push = acc && last;
	assign job.len  = eff_len;
	assign job.trim = trim;
	assign job.err  = 32'(trim2) >= 32'(eff_len);

	// fill counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cfg_len_we) begin
			fill_q <= '0;
		end else if (acc) begin
			fill_q <= last ? '0 : fill_q + 1'b1;
		end
	end

endmodule

@@ rtl/tmf_back.sv @@
module tmf_back #(
	parameter int unsigned MAX_BATCH = tmf_pkg::MAX_BATCH_DEF,
	localparam int unsigned AW = $clog2(MAX_BATCH),
	localparam int unsigned SW = tmf_pkg::SAMPLE_W + AW + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	input  tmf_pkg::job_t                 job,
	output logic                          job_pop,
	output logic                          bank_done,
	output logic [AW-1:0]                 rd_addr,
	input  logic [tmf_pkg::SAMPLE_W-1:0]  rd_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tmf_pkg::SAMPLE_W-1:0]  average,
	output logic                          config_error
);

	tmf_pkg::bk_state_t state_q, state_d;

	logic [tmf_pkg::SAMPLE_W-1:0] buf_q [MAX_BATCH];
	logic [AW:0]                  idx_q;
	logic [AW:0]                  pass_q;
	logic                         odd_q;
	logic                         swapped_q;
	logic [SW-1:0]                sum_q;
	logic [SW-1:0]                rem_q;
	logic [tmf_pkg::SAMPLE_W-1:0] quo_q;
	logic [4:0]                   bit_q;
	logic [AW:0]                  cnt_q;
	logic [tmf_pkg::BLEN_W-1:0]   len_q;
	logic [tmf_pkg::TRIM_W-1:0]   trim_q;
	logic                         err_q;
	logic [tmf_pkg::SAMPLE_W-1:0] avg_q;
	logic                         res_err_q;
	logic                         ld_d1_q;
	logic [AW-1:0]                ld_a1_q;

	logic [SW:0] trial;
	assign trial = {rem_q, quo_q[tmf_pkg::SAMPLE_W-1]} - (SW+1)'(cnt_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tmf_pkg::BK_IDLE: if (job_valid) state_d = job.err ? tmf_pkg::BK_OUT
			                                                : tmf_pkg::BK_LOAD;
			tmf_pkg::BK_LOAD: if (!ld_d1_q && idx_q == (AW+1)'(len_q))
				state_d = tmf_pkg::BK_SORT;
			tmf_pkg::BK_SORT: if (pass_q == (AW+1)'(len_q) + 1'b1) state_d = tmf_pkg::BK_SUM;
			tmf_pkg::BK_SUM:  if (idx_q == (AW+1)'(len_q) - (AW+1)'(trim_q))
				state_d = tmf_pkg::BK_DIV;
			tmf_pkg::BK_DIV:  if (bit_q == 5'd16) state_d = tmf_pkg::BK_OUT;
			tmf_pkg::BK_OUT:  if (!out_stall) state_d = tmf_pkg::BK_IDLE;
			default:          state_d = tmf_pkg::BK_IDLE;
		endcase
	end

	// outputs; the sample bank is free once loaded, or at once for an error job
	always_comb begin
		job_pop      = (state_q == tmf_pkg::BK_IDLE) && job_valid;
		bank_done    = ((state_q == tmf_pkg::BK_IDLE) && job_valid && job.err) ||
		               ((state_q == tmf_pkg::BK_LOAD) && (state_d == tmf_pkg::BK_SORT));
		out_valid    = (state_q == tmf_pkg::BK_OUT);
		average      = avg_q;
		config_error = res_err_q;
		rd_addr      = idx_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmf_pkg::BK_IDLE;
			ld_d1_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ld_d1_q <= (state_q == tmf_pkg::BK_LOAD) && (idx_q < (AW+1)'(len_q));
		end
	end

	// datapath: load, odd-even transposition sort, sum, restoring divide
	always_ff @(posedge clk) begin
		ld_a1_q <= idx_q[AW-1:0];
		case (state_q)
			tmf_pkg::BK_IDLE: begin
				len_q     <= job.len;
				trim_q    <= job.trim;
				err_q     <= job.err;
				idx_q     <= '0;
				avg_q     <= '0;
				res_err_q <= 1'b1;
			end
			tmf_pkg::BK_LOAD: begin
				if (ld_d1_q) buf_q[ld_a1_q] <= rd_data;
				if (idx_q < (AW+1)'(len_q)) idx_q <= idx_q + 1'b1;
				pass_q <= '0;
				odd_q  <= 1'b0;
			end
			tmf_pkg::BK_SORT: begin
				// one empty phase, then len full phases, one compare-exchange per cycle
				if (pass_q == (AW+1)'(len_q) + 1'b1) begin
					idx_q <= (AW+1)'(trim_q);
				end else if (32'(idx_q) + 1 < 32'(len_q)) begin
					if (buf_q[idx_q[AW-1:0]] > buf_q[idx_q[AW-1:0] + 1'b1]) begin
						buf_q[idx_q[AW-1:0]]        <= buf_q[idx_q[AW-1:0] + 1'b1];
						buf_q[idx_q[AW-1:0] + 1'b1] <= buf_q[idx_q[AW-1:0]];
					end
					idx_q <= idx_q + 2'd2;
				end else begin
					pass_q <= pass_q + 1'b1;
					odd_q  <= !odd_q;
					idx_q  <= (AW+1)'(!odd_q);
				end
				swapped_q <= 1'b0;
				sum_q     <= '0;
			end
			tmf_pkg::BK_SUM: begin
				if (idx_q != (AW+1)'(len_q) - (AW+1)'(trim_q)) begin
					sum_q <= sum_q + SW'(buf_q[idx_q[AW-1:0]]);
					idx_q <= idx_q + 1'b1;
				end
				cnt_q <= (AW+1)'(len_q) - (AW+1)'({trim_q, 1'b0});
				rem_q <= '0;
				bit_q <= '0;
			end
			tmf_pkg::BK_DIV: begin
				if (bit_q == 5'd0 && !swapped_q) begin
					// quotient fits 16 bits; shift the sum through quo
					quo_q     <= sum_q[tmf_pkg::SAMPLE_W-1:0];
					rem_q     <= SW'(sum_q >> tmf_pkg::SAMPLE_W);
					swapped_q <= 1'b1;
				end else if (bit_q != 5'd16) begin
					if (!trial[SW]) begin
						rem_q <= trial[SW-1:0];
						quo_q <= {quo_q[tmf_pkg::SAMPLE_W-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[SW-2:0], quo_q[tmf_pkg::SAMPLE_W-1]};
						quo_q <= {quo_q[tmf_pkg::SAMPLE_W-2:0], 1'b0};
					end
					bit_q <= bit_q + 1'b1;
				end
				if (bit_q == 5'd16) begin
					avg_q     <= quo_q;
					res_err_q <= err_q;
				end
			end
			default: ;
		endcase
	end

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && config_error |-> average == '0)
		else $error("error result with nonzero average");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(average))
		else $error("stalled result changed");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> state_q == tmf_pkg::BK_IDLE)
		else $error("job taken while busy");

endmodule
